// ===== rtl/core/npi_pkg.sv =====
// Shared widths, status codes and defaults for the Neville interpolator core.
`timescale 1ns / 1ps

package npi_pkg;

    localparam int XW          = 32;           // abscissa, Q15.16
    localparam int YW          = 48;           // ordinate and value, Q31.16
    localparam int PW          = XW + YW + 1;  // signed product
    localparam int FW          = PW + 1;       // signed product difference
    localparam int DW          = XW + 1;       // abscissa difference magnitude
    localparam int NW          = FW + 1;       // doubled numerator plus half divisor
    localparam int RW          = DW + 1;       // doubled divisor and remainder
    localparam int MAX_PTS_DEF = 16;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EQUAL = 2'd1;
    localparam logic [1:0] STAT_OVF   = 2'd2;
    localparam logic [1:0] STAT_SAT   = 2'd3;

endpackage

// ===== rtl/core/npi_mul.sv =====
// Two-pass signed multiplier for abscissa by ordinate products.
`timescale 1ns / 1ps

module npi_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [npi_pkg::XW-1:0] a,
    input  logic signed [npi_pkg::YW-1:0] b,
    output logic                          done,
    output logic signed [npi_pkg::PW-1:0] prod
);
    import npi_pkg::*;

    localparam int HW = YW / 2;

    typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SGN} mstate_t;

    mstate_t         state_reg;
    logic            done_reg;
    logic [XW-1:0]   ma_reg;
    logic [YW-1:0]   mb_reg;
    logic [PW-2:0]   acc_reg;
    logic            neg_reg;
    logic [PW-1:0]   prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                        state_reg <= M_LO;
                end
                M_LO:    state_reg <= M_HI;
                M_HI:    state_reg <= M_SGN;
                M_SGN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                ma_reg  <= a[XW-1] ? XW'(-a) : XW'(a);
                mb_reg  <= b[YW-1] ? YW'(-b) : YW'(b);
                neg_reg <= a[XW-1] ^ b[YW-1];
            end
            M_LO:    acc_reg <= (PW-1)'(ma_reg * mb_reg[HW-1:0]);
            M_HI:    acc_reg <= acc_reg + ((PW-1)'(ma_reg * mb_reg[YW-1:HW]) << HW);
            M_SGN:   prod_reg <= neg_reg ? PW'(-{1'b0, acc_reg}) : {1'b0, acc_reg};
            default: acc_reg <= acc_reg;
        endcase
    end

    assign done = done_reg;
    assign prod = $signed(prod_reg);

endmodule

// ===== rtl/core/npi_div.sv =====
// Bit-serial restoring divider with round-to-nearest and 48-bit saturation.
`timescale 1ns / 1ps

module npi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [npi_pkg::NW-1:0]        dividend,
    input  logic [npi_pkg::RW-1:0]        divisor,
    input  logic                          neg,
    output logic                          done,
    output logic                          sat,
    output logic signed [npi_pkg::YW-1:0] quot
);
    import npi_pkg::*;

    localparam int QW = YW + 1;
    localparam int CNW = $clog2(NW + 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t         state_reg;
    logic            done_reg;
    logic [CNW-1:0]  cnt_reg;
    logic [NW-1:0]   num_reg;
    logic [RW-1:0]   den_reg;
    logic [RW-1:0]   rem_reg;
    logic [QW-1:0]   q_reg;
    logic            big_reg;
    logic            neg_reg;
    logic            sat_reg;
    logic [YW-1:0]   quot_reg;
    logic [RW:0]     rem_sh;
    logic            ge;
    logic [QW-1:0]   lim;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign lim    = neg_reg ? QW'(1) << (YW - 1) : (QW'(1) << (YW - 1)) - QW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= CNW'(NW - 1);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg - CNW'(1);
                    if (cnt_reg == '0)
                        state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                num_reg <= dividend;
                den_reg <= divisor;
                neg_reg <= neg;
                rem_reg <= '0;
                q_reg   <= '0;
                big_reg <= 1'b0;
            end
            D_RUN:
            begin
                num_reg <= num_reg << 1;
                rem_reg <= ge ? RW'(rem_sh - {1'b0, den_reg}) : RW'(rem_sh);
                big_reg <= big_reg | q_reg[QW-1];
                q_reg   <= {q_reg[QW-2:0], ge};
            end
            D_FIN:
            begin
                if (big_reg || q_reg > lim)
                begin
                    sat_reg  <= 1'b1;
                    quot_reg <= neg_reg ? YW'(-lim) : YW'(lim);
                end
                else
                begin
                    sat_reg  <= 1'b0;
                    quot_reg <= neg_reg ? YW'(-q_reg) : YW'(q_reg);
                end
            end
            default: q_reg <= q_reg;
        endcase
    end

    assign done = done_reg;
    assign sat  = sat_reg;
    assign quot = $signed(quot_reg);

endmodule

// ===== rtl/core/neville_polynomial_interpolator_core.sv =====
// Top level: point store, Neville sequencer and result register.
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_stall  | abscissa, ordinate, is_last
//   result  | out       | out_valid/out_stall| value, status
//
// Points are taken one per cycle while idle; a point with is_last starts the
// evaluation and the input stalls until the result is registered.
// Equality scan: each pair is read, then compared; each update is paced by the
// bit-serial divider and two multiplier passes.
// n points take n*(n-1)/2 pairs plus n*(n-1)/2 updates before the result is emitted.
// Reset clears the sequencer, point count and overflow flag; no memory sweep.
// A result waiting under out_stall does not block new points.
`timescale 1ns / 1ps

module neville_polynomial_interpolator_core #(
    parameter int MAX_POINTS = npi_pkg::MAX_PTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [npi_pkg::XW-1:0] abscissa,
    input  logic signed [npi_pkg::YW-1:0] ordinate,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [npi_pkg::YW-1:0] value,
    output logic [1:0]                    status
);
    import npi_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_EQ_RD, S_EQ_CMP, S_RD1, S_RD2, S_MUL_A, S_WAIT_A,
        S_MUL_B, S_WAIT_B, S_ABS, S_DIV, S_WAIT_D, S_FIN_RD, S_FIN, S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   ovf_reg;
    logic [CW-1:0]          i_reg;
    logic [CW-1:0]          k_reg;
    logic                   sat_reg;
    logic                   out_valid_reg;

    logic signed [XW-1:0]   abs_mem [MAX_POINTS];
    logic signed [YW-1:0]   ord_mem [MAX_POINTS];
    logic signed [XW-1:0]   rax_reg, rbx_reg;
    logic signed [YW-1:0]   ray_reg, rby_reg;

    logic signed [XW-1:0]   xi_reg, xij_reg;
    logic signed [YW-1:0]   yi_reg, yi1_reg;
    logic signed [PW-1:0]   pa_reg;
    logic signed [FW-1:0]   diff_reg;
    logic signed [DW-1:0]   d_reg;
    logic [FW-1:0]          nmag_reg;
    logic [DW-1:0]          dmag_reg;
    logic                   qneg_reg;
    logic signed [YW-1:0]   res_value_reg;
    logic [1:0]             res_status_reg;
    logic signed [YW-1:0]   value_reg;
    logic [1:0]             status_reg;

    logic                   accept;
    logic                   emit;
    logic                   store;
    logic [AW-1:0]          addr_a, addr_b;
    logic [CW:0]            sum_ik1, sum_i2;
    logic [CW:0]            sum_k1;
    logic                   mul_start, mul_done;
    logic signed [XW-1:0]   mul_a;
    logic signed [YW-1:0]   mul_b;
    logic signed [PW-1:0]   mul_prod;
    logic                   div_start, div_done, div_sat;
    logic signed [YW-1:0]   div_quot;
    logic [NW-1:0]          div_num;
    logic [RW-1:0]          div_den;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign store    = accept && (cnt_reg < CW'(MAX_POINTS));
    assign emit     = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign sum_ik1 = {1'b0, i_reg} + {1'b0, k_reg} + (CW+1)'(1);
    assign sum_i2  = {1'b0, i_reg} + (CW+1)'(2);
    assign sum_k1  = {1'b0, k_reg} + (CW+1)'(1);

    always_comb
    begin
        addr_a = i_reg[AW-1:0];
        addr_b = k_reg[AW-1:0];
        case (state_reg)
            S_RD1:    addr_b = AW'(i_reg + k_reg);
            S_RD2:    addr_b = AW'(i_reg + CW'(1));
            S_FIN_RD: addr_a = '0;
            default:  addr_b = k_reg[AW-1:0];
        endcase
    end

    assign mul_start = (state_reg == S_MUL_A) || (state_reg == S_MUL_B);
    assign mul_a     = (state_reg == S_MUL_A) ? xij_reg : xi_reg;
    assign mul_b     = (state_reg == S_MUL_A) ? yi_reg : yi1_reg;
    assign div_start = (state_reg == S_DIV);
    assign div_num   = NW'({nmag_reg[FW-2:0], 1'b0}) + NW'(dmag_reg);
    assign div_den   = {dmag_reg, 1'b0};

    npi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    npi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .neg      (qneg_reg),
        .done     (div_done),
        .sat      (div_sat),
        .quot     (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            abs_mem[cnt_reg[AW-1:0]] <= abscissa;
            ord_mem[cnt_reg[AW-1:0]] <= ordinate;
        end
        else if (state_reg == S_WAIT_D && div_done)
            ord_mem[i_reg[AW-1:0]] <= div_quot;
        rax_reg <= abs_mem[addr_a];
        ray_reg <= ord_mem[addr_a];
        rbx_reg <= abs_mem[addr_b];
        rby_reg <= ord_mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !emit)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (store)
                            cnt_reg <= cnt_reg + CW'(1);
                        else
                            ovf_reg <= 1'b1;
                        if (is_last)
                            state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    sat_reg <= 1'b0;
                    i_reg   <= '0;
                    k_reg   <= CW'(1);
                    if (ovf_reg)
                        state_reg <= S_EMIT;
                    else if (cnt_reg < CW'(2))
                        state_reg <= S_FIN_RD;
                    else
                        state_reg <= S_EQ_RD;
                end
                S_EQ_RD: state_reg <= S_EQ_CMP;
                S_EQ_CMP:
                begin
                    if (rax_reg == rbx_reg)
                        state_reg <= S_EMIT;
                    else if (sum_k1 < {1'b0, cnt_reg})
                    begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= S_EQ_RD;
                    end
                    else if (sum_i2 < {1'b0, cnt_reg})
                    begin
                        i_reg     <= i_reg + CW'(1);
                        k_reg     <= CW'(sum_i2);
                        state_reg <= S_EQ_RD;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        k_reg     <= CW'(1);
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:   state_reg <= S_RD2;
                S_RD2:   state_reg <= S_MUL_A;
                S_MUL_A: state_reg <= S_WAIT_A;
                S_WAIT_A:
                begin
                    if (mul_done)
                        state_reg <= S_MUL_B;
                end
                S_MUL_B: state_reg <= S_WAIT_B;
                S_WAIT_B:
                begin
                    if (mul_done)
                        state_reg <= S_ABS;
                end
                S_ABS:   state_reg <= S_DIV;
                S_DIV:   state_reg <= S_WAIT_D;
                S_WAIT_D:
                begin
                    if (div_done)
                    begin
                        sat_reg <= sat_reg | div_sat;
                        if (sum_ik1 < {1'b0, cnt_reg})
                        begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= S_RD1;
                        end
                        else if (sum_k1 < {1'b0, cnt_reg})
                        begin
                            i_reg     <= '0;
                            k_reg     <= k_reg + CW'(1);
                            state_reg <= S_RD1;
                        end
                        else
                            state_reg <= S_FIN_RD;
                    end
                end
                S_FIN_RD: state_reg <= S_FIN;
                S_FIN:    state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (emit)
                    begin
                        out_valid_reg <= 1'b1;
                        cnt_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_CHECK:
            begin
                res_value_reg  <= '0;
                res_status_reg <= STAT_OVF;
            end
            S_EQ_CMP:
            begin
                res_value_reg  <= '0;
                res_status_reg <= STAT_EQUAL;
            end
            S_RD2:
            begin
                xi_reg  <= rax_reg;
                yi_reg  <= ray_reg;
                xij_reg <= rbx_reg;
                d_reg   <= DW'(rbx_reg) - DW'(rax_reg);
            end
            S_MUL_A:  yi1_reg <= rby_reg;
            S_WAIT_A:
            begin
                if (mul_done)
                    pa_reg <= mul_prod;
            end
            S_WAIT_B:
            begin
                if (mul_done)
                    diff_reg <= FW'(pa_reg) - FW'(mul_prod);
            end
            S_ABS:
            begin
                nmag_reg <= diff_reg[FW-1] ? FW'(-diff_reg) : FW'(diff_reg);
                dmag_reg <= d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
                qneg_reg <= diff_reg[FW-1] ^ d_reg[DW-1];
            end
            S_FIN:
            begin
                res_value_reg  <= ray_reg;
                res_status_reg <= sat_reg ? STAT_SAT : STAT_OK;
            end
            default: xi_reg <= xi_reg;
        endcase
        if (emit)
        begin
            value_reg  <= res_value_reg;
            status_reg <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

// ===== rtl/core/npi_checker.sv =====
// Port-level checks for the Neville interpolator core, bound to the top level.
`timescale 1ns / 1ps

module npi_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic signed [npi_pkg::XW-1:0] abscissa,
    input logic signed [npi_pkg::YW-1:0] ordinate,
    input logic                          is_last,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [npi_pkg::YW-1:0] value,
    input logic [1:0]                    status
);
    import npi_pkg::*;

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && is_last |=> in_stall)
        else $error("input not stalled after final point");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_EQUAL || status == STAT_OVF) |-> value == '0)
        else $error("error status with non-zero value");

    a_rise_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("transaction produced without evaluation");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("stalled result changed");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(abscissa) && $stable(ordinate)
            && $stable(is_last))
        else $error("stalled input transaction changed");

endmodule

bind neville_polynomial_interpolator_core npi_checker u_npi_checker (.*);
